// File: rtl/plist_pkg.sv
package plist_pkg;

	// request codes carried in the input tuser
	typedef enum logic [2:0] {
		KIND_INSERT   = 3'd0,
		KIND_DELETE   = 3'd1,
		KIND_GET      = 3'd2,
		KIND_LOCATE   = 3'd3,
		KIND_PRED     = 3'd4,
		KIND_SUCC     = 3'd5,
		KIND_CLEAR    = 3'd6,
		KIND_TRAVERSE = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	localparam int POS_W   = 8;
	localparam int VAL_W   = 32;
	localparam int RPOS_W  = 7;
	localparam int LEN_W   = 7;

	// packed so result_value lands in the lowest bits
	typedef struct packed {
		logic              is_empty;
		logic [LEN_W-1:0]  list_length;
		status_t           status;
		logic [RPOS_W-1:0] result_position;
		logic [VAL_W-1:0]  result_value;
	} result_t;

	localparam int RES_W       = $bits(result_t);
	localparam int IN_TDATA_W  = POS_W + VAL_W;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;

endpackage

// File: rtl/plist_mem.sv
module plist_mem #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [plist_pkg::VAL_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [plist_pkg::VAL_W-1:0] rd_data
);
	import plist_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/plist_ctrl.sv
module plist_ctrl #(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  plist_pkg::kind_t            req_kind,
	input  logic [plist_pkg::POS_W-1:0] req_position,
	input  logic [plist_pkg::VAL_W-1:0] req_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output plist_pkg::result_t          res_data,
	output logic                        res_last,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [plist_pkg::VAL_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [plist_pkg::VAL_W-1:0] rd_data
);
	import plist_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_UP      = 10'b00_0000_0010,
		S_PLACE   = 10'b00_0000_0100,
		S_DOWN    = 10'b00_0000_1000,
		S_GET     = 10'b00_0001_0000,
		S_GET_D   = 10'b00_0010_0000,
		S_SCAN    = 10'b00_0100_0000,
		S_TRAV_RD = 10'b00_1000_0000,
		S_TRAV_EM = 10'b01_0000_0000,
		S_EMIT    = 10'b10_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic             iss_q, iss_d;
	logic             v_s1, v_d;
	logic [AW-1:0]    idx_s1;
	logic             out_valid_q, out_valid_d;

	kind_t            kind_q, kind_d;
	logic [AW-1:0]    pos_idx_q, pos_idx_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [AW-1:0]    ra_q, ra_d;
	logic [AW-1:0]    end_q, end_d;
	logic [VAL_W-1:0] prev_q, prev_d;
	logic [VAL_W-1:0] pend_val_q, pend_val_d;
	logic [RPOS_W-1:0] pend_pos_q, pend_pos_d;
	status_t          pend_st_q, pend_st_d;
	result_t          out_q, out_d;
	logic             out_last_q, out_last_d;

	logic             out_free;
	logic             load_out;
	logic             hit;
	logic [8:0]       pos_w, cnt_w;
	logic             full;
	logic [AW-1:0]    req_idx;
	logic [AW-1:0]    last_idx;

	assign out_free  = !out_valid_q || res_ready;
	assign req_ready = (state_q == S_IDLE);
	assign pos_w     = 9'(req_position);
	assign cnt_w     = 9'(count_q);
	assign full      = (count_q == CW'(CAPACITY));
	assign req_idx   = AW'(req_position - POS_W'(1));
	assign last_idx  = AW'(count_q - CW'(1));

	always_comb begin
		hit = 1'b0;
		case (kind_q)
			KIND_LOCATE: hit = (rd_data == val_q);
			KIND_PRED:   hit = (idx_s1 != '0) && (rd_data == val_q);
			KIND_SUCC:   hit = (idx_s1 != '0) && (prev_q == val_q);
			default:     hit = 1'b0;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		iss_d      = iss_q;
		kind_d     = kind_q;
		pos_idx_d  = pos_idx_q;
		val_d      = val_q;
		ra_d       = ra_q;
		end_d      = end_q;
		prev_d     = prev_q;
		pend_val_d = pend_val_q;
		pend_pos_d = pend_pos_q;
		pend_st_d  = pend_st_q;
		out_d      = out_q;
		out_last_d = out_last_q;
		load_out   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = ra_q;
		wr_en      = 1'b0;
		wr_addr    = ra_q;
		wr_data    = rd_data;

		// address walker for shift and scan passes
		v_d = iss_q;
		if (iss_q) begin
			rd_en = 1'b1;
			if (ra_q == end_q) begin
				iss_d = 1'b0;
			end else if (state_q == S_UP) begin
				ra_d = ra_q - AW'(1);
			end else begin
				ra_d = ra_q + AW'(1);
			end
		end

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					kind_d     = req_kind;
					val_d      = req_value;
					pend_val_d = '0;
					pend_pos_d = '0;
					pend_st_d  = ST_OK;
					state_d    = S_EMIT;
					unique case (req_kind)
						KIND_INSERT: begin
							if (full) begin
								pend_st_d = ST_FULL;
							end else if (pos_w == '0 || pos_w > cnt_w + 9'd1) begin
								pend_st_d = ST_BADPOS;
							end else begin
								pos_idx_d = req_idx;
								if (pos_w == cnt_w + 9'd1) begin
									state_d = S_PLACE;
								end else begin
									ra_d    = last_idx;
									end_d   = req_idx;
									iss_d   = 1'b1;
									state_d = S_UP;
								end
							end
						end
						KIND_DELETE: begin
							if (pos_w == '0 || pos_w > cnt_w) begin
								pend_st_d = ST_BADPOS;
							end else begin
								pos_idx_d = req_idx;
								ra_d      = req_idx;
								end_d     = last_idx;
								iss_d     = 1'b1;
								state_d   = S_DOWN;
							end
						end
						KIND_GET: begin
							if (pos_w == '0 || pos_w > cnt_w) begin
								pend_st_d = ST_BADPOS;
							end else begin
								ra_d    = req_idx;
								state_d = S_GET;
							end
						end
						KIND_LOCATE, KIND_PRED, KIND_SUCC: begin
							if (count_q == '0) begin
								pend_st_d = ST_NOTFOUND;
							end else begin
								ra_d    = '0;
								end_d   = last_idx;
								iss_d   = 1'b1;
								state_d = S_SCAN;
							end
						end
						KIND_CLEAR: begin
							count_d = '0;
						end
						KIND_TRAVERSE: begin
							if (count_q == '0) begin
								pend_st_d = ST_EMPTY;
							end else begin
								ra_d    = '0;
								end_d   = last_idx;
								state_d = S_TRAV_RD;
							end
						end
						default: pend_st_d = ST_OK;
					endcase
				end
			end
			S_UP: begin
				// entry idx moves one place toward the tail
				if (v_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 + AW'(1);
					if (idx_s1 == end_q) begin
						state_d = S_PLACE;
					end
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_idx_q;
				wr_data = val_q;
				count_d = count_q + CW'(1);
				state_d = S_EMIT;
			end
			S_DOWN: begin
				// first read is the removed entry, the rest move toward the head
				if (v_s1) begin
					if (idx_s1 == pos_idx_q) begin
						pend_val_d = rd_data;
					end else begin
						wr_en   = 1'b1;
						wr_addr = idx_s1 - AW'(1);
					end
					if (idx_s1 == end_q) begin
						count_d = count_q - CW'(1);
						state_d = S_EMIT;
					end
				end
			end
			S_GET: begin
				rd_en   = 1'b1;
				state_d = S_GET_D;
			end
			S_GET_D: begin
				pend_val_d = rd_data;
				state_d    = S_EMIT;
			end
			S_SCAN: begin
				if (v_s1) begin
					prev_d = rd_data;
					if (hit) begin
						iss_d = 1'b0;
						if (kind_q == KIND_LOCATE) begin
							pend_pos_d = RPOS_W'(idx_s1) + RPOS_W'(1);
						end else if (kind_q == KIND_PRED) begin
							pend_val_d = prev_q;
						end else begin
							pend_val_d = rd_data;
						end
						state_d = S_EMIT;
					end else if (idx_s1 == end_q) begin
						iss_d     = 1'b0;
						pend_st_d = ST_NOTFOUND;
						state_d   = S_EMIT;
					end
				end
			end
			S_TRAV_RD: begin
				rd_en   = 1'b1;
				state_d = S_TRAV_EM;
			end
			S_TRAV_EM: begin
				if (out_free) begin
					load_out                = 1'b1;
					out_d.result_value      = rd_data;
					out_d.result_position   = RPOS_W'(ra_q) + RPOS_W'(1);
					out_d.status            = ST_OK;
					out_d.list_length       = LEN_W'(count_q);
					out_d.is_empty          = 1'b0;
					out_last_d              = (ra_q == end_q);
					if (ra_q == end_q) begin
						state_d = S_IDLE;
					end else begin
						ra_d    = ra_q + AW'(1);
						rd_en   = 1'b1;
						rd_addr = ra_q + AW'(1);
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load_out              = 1'b1;
					out_d.result_value    = pend_val_q;
					out_d.result_position = pend_pos_q;
					out_d.status          = pend_st_q;
					out_d.list_length     = LEN_W'(count_q);
					out_d.is_empty        = (count_q == '0);
					out_last_d            = 1'b1;
					state_d               = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (res_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			iss_q       <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			iss_q       <= iss_d;
			v_s1        <= v_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= ra_q;
		kind_q     <= kind_d;
		pos_idx_q  <= pos_idx_d;
		val_q      <= val_d;
		ra_q       <= ra_d;
		end_q      <= end_d;
		prev_q     <= prev_d;
		pend_val_q <= pend_val_d;
		pend_pos_q <= pend_pos_d;
		pend_st_q  <= pend_st_d;
		out_q      <= out_d;
		out_last_q <= out_last_d;
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;
	assign res_last  = out_last_q;

endmodule

// File: rtl/positional_list_engine_top.sv
// Sequence: a request is taken in S_IDLE; get reads its entry in S_GET and S_GET_D, clear resets
// the count, insert shifts in S_UP then writes in S_PLACE, delete shifts in S_DOWN, and
// locate/predecessor/successor scan in S_SCAN, each ending in S_EMIT; traversal streams one
// result per cycle unless m_axis_tready holds it back. One request at a time; every shift
// or scan walks through the single read port of the element memory.
// Reset (arst_n low) empties the list and drops any pending result; memory is not cleared.
module positional_list_engine_top #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request side
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata, low bit up: position[7:0], value[39:8]
	input  logic [plist_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: kind[2:0]
	input  plist_pkg::kind_t                   s_axis_tuser,
	// result side
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata, low bit up: result_value[31:0], result_position[38:32], status[41:39],
	// list_length[48:42], is_empty[49], zero fill[55:50]
	output logic [plist_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// tlast: final result item of the request
	output logic                               m_axis_tlast
);
	import plist_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;
	result_t          res_data;

	// element store: one write and one registered read per cycle
	plist_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer: decodes a request, walks the memory, holds the result register
	// so a finished item can wait on m_axis_tready while the next one is taken
	plist_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (s_axis_tvalid),
		.req_ready    (s_axis_tready),
		.req_kind     (s_axis_tuser),
		.req_position (s_axis_tdata[POS_W-1:0]),
		.req_value    (s_axis_tdata[IN_TDATA_W-1:POS_W]),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_data     (res_data),
		.res_last     (m_axis_tlast),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_data};

endmodule
